// ===== hdl/tqgsu_pkg.sv =====
// Shared types and constants for the two-qubit gate state update unit.
package tqgsu_pkg;

    localparam int DATA_W      = 32;   // one real or imaginary part
    localparam int ACC_W       = 67;   // exact sum of eight 64-bit products
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 64;
    localparam logic [3:0] QCOUNT_RESET = 4'd10;

    typedef enum logic [1:0] {
        ACT_WR_AMP  = 2'd0,
        ACT_WR_COEF = 2'd1,
        ACT_APPLY   = 2'd2,
        ACT_RD_AMP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EQUAL = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ===== hdl/two_qubit_gate_state_update_unit.sv =====
// Two-qubit gate on a fixed-point state vector: amplitude memory, gate registers, MAC sequencer.
//
// The unit takes one word at a time and answers each with exactly one result word. Writing an
// amplitude or a coefficient goes from idle straight to the result state, and reading an amplitude
// passes through a read-wait state first; the result sits in an output register, so a new word is
// taken while it waits. Applying the gate walks the 2^(n-2) groups of four amplitudes for n
// active qubits: per group a step forms the base index, a load phase reads the four amplitudes
// through the single memory read port, and each of the four rows takes a multiply step per product
// term on the one shared 32x32 multiplier plus a drain and a write-back step. The amplitude memory
// and the coefficient registers power up undefined and must be written before use; there is no
// clearing pass. The qubit count register is to be written over its own channel only while the
// unit is idle, which the unit does not enforce; the count used is clamped to 2..MAX_QUBITS.
module two_qubit_gate_state_update_unit
    import tqgsu_pkg::*;
#(
    parameter int MAX_QUBITS = 10,
    parameter int FRAC_BITS  = 30
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_data,     // qubit_count
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // amp_index[9:0], coef_index[13:10], value_re[45:14], value_im[77:46],
    // target_a[81:78], target_b[85:82], zero fill[87:86]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,   // action[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // out_re[31:0], out_im[63:32]
    output logic [1:0]           m_axis_tuser    // status[1:0]
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int GW    = (MAX_QUBITS > 2) ? MAX_QUBITS - 2 : 1;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_GRP,
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_WR,
        S_OUT
    } t_state;

    function automatic logic [AW-1:0] ins0(input logic [AW-1:0] v, input logic [3:0] pos);
        logic [AW-1:0] tail_bits;
        tail_bits = (AW'(1) << pos) - AW'(1);
        return ((v >> pos) << (5'(pos) + 5'd1)) | (v & tail_bits);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + RND) >>> FRAC_BITS;
        if (t > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end else if (t < SAT_LO) begin
            return 32'sh80000000;
        end
        return t[DATA_W-1:0];
    endfunction

    // input word fields
    logic [9:0]               in_amp;
    logic [3:0]               in_coef;
    logic signed [DATA_W-1:0] in_re;
    logic signed [DATA_W-1:0] in_im;
    logic [3:0]               in_ta;
    logic [3:0]               in_tb;
    t_action                  in_act;

    assign in_amp  = s_axis_tdata[9:0];
    assign in_coef = s_axis_tdata[13:10];
    assign in_re   = s_axis_tdata[45:14];
    assign in_im   = s_axis_tdata[77:46];
    assign in_ta   = s_axis_tdata[81:78];
    assign in_tb   = s_axis_tdata[85:82];
    assign in_act  = t_action'(s_axis_tuser);

    t_state                   r_state, n_state;
    logic [3:0]               r_qcount;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_re, r_out_im;
    t_status                  r_out_st;
    logic signed [DATA_W-1:0] r_res_re, r_res_im;
    t_status                  r_res_st;
    logic [AW-1:0]            r_bit_a, r_bit_b, r_base;
    logic [3:0]               r_lo, r_hi;
    logic [GW-1:0]            r_grp;
    logic [2:0]               r_cnt;
    logic [1:0]               r_row;
    logic [3:0]               r_step;
    logic signed [DATA_W-1:0] r_vre [4];
    logic signed [DATA_W-1:0] r_vim [4];
    logic signed [DATA_W-1:0] r_coef_re [16];
    logic signed [DATA_W-1:0] r_coef_im [16];
    logic signed [63:0]       r_prod;
    logic                     r_p_valid, r_p_neg, r_p_im;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic [63:0]              r_rdata;
    logic [63:0]              mem [DEPTH];

    logic [3:0]               q_n;
    logic                     amp_bad, tgt_bad, tgt_eq, in_fire, grp_last;
    logic [GW-1:0]            grp_top;
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [63:0]              mem_wdata;
    logic [1:0]               ld_col, term;
    logic [3:0]               cidx;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0]       mul_p;
    logic signed [ACC_W-1:0]  p_ext;

    // clamp the qubit count to the supported range
    always_comb begin
        if (r_qcount < 4'd2) begin
            q_n = 4'd2;
        end else if (32'(r_qcount) > MAX_QUBITS) begin
            q_n = 4'(MAX_QUBITS);
        end else begin
            q_n = r_qcount;
        end
    end

    assign amp_bad  = (in_amp >> q_n) != '0;
    assign tgt_bad  = (in_ta >= q_n) || (in_tb >= q_n);
    assign tgt_eq   = in_ta == in_tb;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign grp_top  = GW'((32'd1 << (q_n - 4'd2)) - 32'd1);
    assign grp_last = r_grp == grp_top;
    assign ld_col   = 2'(r_cnt - 3'd1);

    assign s_axis_tready = r_state == S_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tuser  = r_out_st;

    // shared multiplier: term 0 mr*vr, 1 -mi*vi (real), 2 mr*vi, 3 mi*vr (imaginary)
    assign term  = r_step[1:0];
    assign cidx  = {r_row, r_step[3:2]};
    assign mul_a = term[0] ? r_coef_im[cidx] : r_coef_re[cidx];
    assign mul_b = (term[0] ^ term[1]) ? r_vim[r_step[3:2]] : r_vre[r_step[3:2]];
    assign mul_p = mul_a * mul_b;
    assign p_ext = ACC_W'(r_prod);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(in_amp);
        mem_wdata = {in_im, in_re};
        mem_re    = 1'b0;
        mem_raddr = AW'(in_amp);
        case (r_state)
            S_IDLE: begin
                mem_we = in_fire && (in_act == ACT_WR_AMP) && !amp_bad;
                mem_re = in_fire && (in_act == ACT_RD_AMP) && !amp_bad;
            end
            S_LOAD: begin
                mem_re    = r_cnt < 3'd4;
                mem_raddr = r_base | (r_cnt[0] ? r_bit_a : '0) | (r_cnt[1] ? r_bit_b : '0);
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_base | (r_row[0] ? r_bit_a : '0) | (r_row[1] ? r_bit_b : '0);
                mem_wdata = {round_sat(r_acc_im), round_sat(r_acc_re)};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_act)
                        ACT_RD_AMP: n_state = amp_bad ? S_OUT : S_RDWAIT;
                        ACT_APPLY:  n_state = (tgt_bad || tgt_eq) ? S_OUT : S_GRP;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_OUT;
            S_GRP:    n_state = S_LOAD;
            S_LOAD:   n_state = (r_cnt == 3'd4) ? S_MAC : S_LOAD;
            S_MAC:    n_state = (r_step == 4'd15) ? S_DRAIN : S_MAC;
            S_DRAIN:  n_state = S_WR;
            S_WR: begin
                if (r_row != 2'd3) begin
                    n_state = S_MAC;
                end else begin
                    n_state = grp_last ? S_OUT : S_GRP;
                end
            end
            S_OUT:    n_state = (!r_out_valid || m_axis_tready) ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qcount    <= QCOUNT_RESET;
            r_out_valid <= 1'b0;
            r_p_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_qcount <= i_cfg_data;
            end
            // a result reloading in S_OUT keeps the register full
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            r_p_valid <= r_state == S_MAC;
            r_prod    <= mul_p;
            r_p_neg   <= term == 2'd1;
            r_p_im    <= term[1];
            if (r_p_valid) begin
                if (r_p_im) begin
                    r_acc_im <= r_p_neg ? r_acc_im - p_ext : r_acc_im + p_ext;
                end else begin
                    r_acc_re <= r_p_neg ? r_acc_re - p_ext : r_acc_re + p_ext;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_res_re <= '0;
                        r_res_im <= '0;
                        r_lo     <= (in_ta < in_tb) ? in_ta : in_tb;
                        r_hi     <= (in_ta < in_tb) ? in_tb : in_ta;
                        r_bit_a  <= AW'(1) << in_ta;
                        r_bit_b  <= AW'(1) << in_tb;
                        r_grp    <= '0;
                        case (in_act)
                            ACT_WR_COEF: begin
                                r_coef_re[in_coef] <= in_re;
                                r_coef_im[in_coef] <= in_im;
                                r_res_st           <= ST_DONE;
                            end
                            ACT_APPLY: begin
                                if (tgt_bad) begin
                                    r_res_st <= ST_RANGE;
                                end else if (tgt_eq) begin
                                    r_res_st <= ST_EQUAL;
                                end else begin
                                    r_res_st <= ST_DONE;
                                end
                            end
                            default: r_res_st <= amp_bad ? ST_RANGE : ST_DONE;
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_res_re <= r_rdata[31:0];
                    r_res_im <= r_rdata[63:32];
                end
                S_GRP: begin
                    r_base   <= ins0(ins0(AW'(r_grp), r_lo), r_hi);
                    r_cnt    <= '0;
                    r_row    <= '0;
                    r_step   <= '0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_vre[ld_col] <= r_rdata[31:0];
                        r_vim[ld_col] <= r_rdata[63:32];
                    end
                end
                S_MAC: r_step <= r_step + 4'd1;
                S_WR: begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    r_step   <= '0;
                    r_row    <= r_row + 2'd1;
                    if (r_row == 2'd3) begin
                        r_grp <= r_grp + GW'(1);
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_re    <= r_res_re;
                        r_out_im    <= r_res_im;
                        r_out_st    <= r_res_st;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_mem_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE || r_state == S_WR))
        else $error("amplitude memory written outside idle or write-back");

    a_prod_from_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> ($past(r_state) == S_MAC))
        else $error("product valid without a multiply step");

    a_flagged_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == '0))
        else $error("flagged result carries nonzero data");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || m_axis_tready))
            |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("result not presented after completion");

endmodule
